@@ sv/mac_rx_frame_parse_filter_top_assert.svh @@
// assertion macros for the frame parser
`ifndef MAC_RX_FRAME_PARSE_FILTER_TOP_ASSERT_SVH
`define MAC_RX_FRAME_PARSE_FILTER_TOP_ASSERT_SVH

`define MRFP_ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define MRFP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `MRFP_ASSERT_IMPL(lbl, clk, rst_n, !(cond))

`endif

@@ sv/mrfp_pkg.sv @@
package mrfp_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FCS    = 3'd1;
  localparam logic [2:0] ST_CRC_BAD   = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_SECURED   = 3'd4;
  localparam logic [2:0] ST_ACK_ADDR  = 3'd5;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd6;

  localparam logic [1:0] CLS_HOST  = 2'd0;
  localparam logic [1:0] CLS_BCAST = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  localparam logic [1:0] AM_NONE  = 2'd0;
  localparam logic [1:0] AM_SHORT = 2'd2;
  localparam logic [1:0] AM_LONG  = 2'd3;

  localparam logic [2:0] FT_ACK = 3'd2;

  localparam logic [1:0] REG_OMIT  = 2'd0;
  localparam logic [1:0] REG_PAN   = 2'd1;
  localparam logic [1:0] REG_SHORT = 2'd2;
  localparam logic [1:0] REG_EXT   = 2'd3;

  localparam logic [15:0] CRC_POLY = 16'h8408;

  // frame summary handed from the byte front end to the result stage
  typedef struct packed {
    logic        omit;
    logic        short_frame;
    logic        crc_bad;
    logic [4:0]  parse_pos;
    logic [15:0] fc;
    logic [7:0]  seq;
    logic [15:0] dst_pan;
    logic [63:0] dst_addr;
    logic [15:0] src_pan;
    logic [63:0] src_addr;
    logic [15:0] own_pan;
    logic [15:0] own_short;
    logic [63:0] own_ext;
  } frame_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  frame_type;
    logic        ack_request;
    logic        pan_compress;
    logic [7:0]  seq_num;
    logic [1:0]  dst_mode;
    logic [15:0] dst_pan;
    logic [63:0] dst_address;
    logic [1:0]  src_mode;
    logic [15:0] src_pan;
    logic [63:0] src_address;
    logic [1:0]  packet_class;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [4:0] mode_bytes(input logic [1:0] m);
    return (m == AM_SHORT) ? 5'd2 : 5'd8;
  endfunction

endpackage

@@ sv/mrfp_front.sv @@
module mrfp_front import mrfp_pkg::*; #(
  parameter int MaxFrameLen = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  output logic        in_stall_o,
  input  logic        cfg_omit_i,
  input  logic [15:0] cfg_pan_i,
  input  logic [15:0] cfg_short_i,
  input  logic [63:0] cfg_ext_i,
  output logic        q_push_o,
  output frame_t      q_data_o,
  input  logic        q_full_i
);

  logic [15:0] crc_q, crc_d;
  logic [6:0]  cnt_q;
  logic [4:0]  pos_q;
  logic [7:0]  dly0_q, dly1_q;
  logic [15:0] fc_q, fc_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] dpan_q, dpan_d, span_q, span_d;
  logic [63:0] dadr_q, dadr_d, sadr_q, sadr_d;
  logic [4:0]  pos_d;
  logic        acc;
  logic        live;
  logic        take;
  logic [7:0]  tb;
  logic [6:0]  cnt_d;

  assign in_stall_o = frame_end_i & q_full_i;
  assign acc  = in_valid_i & ~in_stall_o;
  assign live = cnt_q < 7'(MaxFrameLen);
  assign take = live & (cfg_omit_i | (cnt_q >= 7'd2));
  assign tb   = cfg_omit_i ? rx_byte_i : dly1_q;

  always_comb begin
    logic [1:0] da, sa;
    logic [4:0] n, p, l, off;
    fc_d = fc_q; seq_d = seq_q; dpan_d = dpan_q; dadr_d = dadr_q;
    span_d = span_q; sadr_d = sadr_q;
    da = fc_q[11:10]; sa = fc_q[15:14];
    n = pos_q; p = 5'd3; off = '0; l = '0;
    pos_d = (take && pos_q != 5'd31) ? pos_q + 5'd1 : pos_q;
    crc_d = live ? crc_byte(crc_q, rx_byte_i) : crc_q;
    cnt_d = live ? cnt_q + 7'd1 : cnt_q;
    if (take) begin
      if (n == 5'd0) fc_d = {8'h00, tb};
      else if (n == 5'd1) fc_d = {tb, fc_q[7:0]};
      else if (n == 5'd2) seq_d = tb;
      else begin
        if (da != AM_NONE && n < p + 5'd2) begin
          off = n - p;
          dpan_d = dpan_q | ({8'h00, tb} << {off[0], 3'b000});
          p = 5'd31;
        end else if (da != AM_NONE) begin
          p = p + 5'd2;
          l = mode_bytes(da);
          if (n < p + l) begin
            off = n - p;
            dadr_d = dadr_q | ({56'h0, tb} << {off[2:0], 3'b000});
            p = 5'd31;
          end else p = p + l;
        end
        if (p != 5'd31 && sa != AM_NONE) begin
          if (!fc_q[6] && n < p + 5'd2) begin
            off = n - p;
            span_d = span_q | ({8'h00, tb} << {off[0], 3'b000});
          end else begin
            if (!fc_q[6]) p = p + 5'd2;
            l = mode_bytes(sa);
            if (n < p + l) begin
              off = n - p;
              sadr_d = sadr_q | ({56'h0, tb} << {off[2:0], 3'b000});
            end
          end
        end
      end
    end
  end

  always_comb begin
    q_data_o.omit        = cfg_omit_i;
    q_data_o.short_frame = cnt_d < 7'd2;
    q_data_o.crc_bad     = crc_d != 16'h0;
    q_data_o.parse_pos   = pos_d;
    q_data_o.fc          = fc_d;
    q_data_o.seq         = seq_d;
    q_data_o.dst_pan     = dpan_d;
    q_data_o.dst_addr    = dadr_d;
    q_data_o.src_pan     = span_d;
    q_data_o.src_addr    = sadr_d;
    q_data_o.own_pan     = cfg_pan_i;
    q_data_o.own_short   = cfg_short_i;
    q_data_o.own_ext     = cfg_ext_i;
  end
  assign q_push_o = acc & frame_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= '0; cnt_q <= '0; pos_q <= '0; dly0_q <= '0; dly1_q <= '0;
      fc_q <= '0; seq_q <= '0; dpan_q <= '0; dadr_q <= '0; span_q <= '0; sadr_q <= '0;
    end else if (acc) begin
      if (frame_end_i) begin
        crc_q <= '0; cnt_q <= '0; pos_q <= '0; dly0_q <= '0; dly1_q <= '0;
        fc_q <= '0; seq_q <= '0; dpan_q <= '0; dadr_q <= '0; span_q <= '0;
        sadr_q <= '0;
      end else begin
        crc_q <= crc_d; cnt_q <= cnt_d; pos_q <= pos_d;
        if (live) begin
          dly1_q <= dly0_q; dly0_q <= rx_byte_i;
        end
        fc_q <= fc_d; seq_q <= seq_d; dpan_q <= dpan_d; dadr_q <= dadr_d;
        span_q <= span_d; sadr_q <= sadr_d;
      end
    end
  end

endmodule

@@ sv/mrfp_back.sv @@
module mrfp_back import mrfp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_push_i,
  input  frame_t  q_data_i,
  output logic    q_full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  frame_t  fq_q;
  logic    fv_q;
  result_t r_d;
  logic    pop;

  assign pop = fv_q & ~out_stall_i;
  assign q_full_o = fv_q & out_stall_i;
  assign out_valid_o = fv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fv_q <= 1'b0;
    else if (q_push_i) fv_q <= 1'b1;
    else if (pop) fv_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (q_push_i) fq_q <= q_data_i;
  end

  always_comb begin
    logic [2:0] ty, st;
    logic [1:0] da, sa, cls;
    logic [4:0] hl;
    ty = fq_q.fc[2:0]; da = fq_q.fc[11:10]; sa = fq_q.fc[15:14];
    hl = 5'd3;
    if (da != AM_NONE) hl = hl + 5'd2 + mode_bytes(da);
    if (sa != AM_NONE) hl = hl + (fq_q.fc[6] ? 5'd0 : 5'd2) + mode_bytes(sa);
    priority if (!fq_q.omit && fq_q.short_frame) st = ST_NO_FCS;
    else if (!fq_q.omit && fq_q.crc_bad) st = ST_CRC_BAD;
    else if (fq_q.parse_pos < 5'd3) st = ST_TRUNC;
    else if (fq_q.fc[3]) st = ST_SECURED;
    else if (ty == FT_ACK && (da != AM_NONE || sa != AM_NONE)) st = ST_ACK_ADDR;
    else if (fq_q.parse_pos < hl) st = ST_TRUNC;
    else if (ty[2]) st = ST_BAD_TYPE;
    else st = ST_OK;
    priority if (da == AM_NONE) cls = (sa != AM_NONE) ? CLS_OTHER : CLS_HOST;
    else if (fq_q.dst_pan != fq_q.own_pan && fq_q.dst_pan != 16'hFFFF) cls = CLS_OTHER;
    else if (da == AM_LONG) cls = (fq_q.dst_addr == fq_q.own_ext) ? CLS_HOST : CLS_OTHER;
    else if (da == AM_SHORT && fq_q.dst_addr == {48'h0, fq_q.own_short}) cls = CLS_HOST;
    else if (da == AM_SHORT && fq_q.dst_addr == 64'hFFFF) cls = CLS_BCAST;
    else cls = CLS_OTHER;
    r_d = '0;
    r_d.status = st;
    if (st == ST_OK || st == ST_BAD_TYPE) begin
      r_d.frame_type   = ty;
      r_d.ack_request  = fq_q.fc[5];
      r_d.pan_compress = fq_q.fc[6];
      r_d.seq_num      = fq_q.seq;
      r_d.dst_mode     = da;
      r_d.dst_pan      = fq_q.dst_pan;
      r_d.dst_address  = fq_q.dst_addr;
      r_d.src_mode     = sa;
      r_d.src_pan      = (fq_q.fc[6] && da != AM_NONE) ? fq_q.dst_pan : fq_q.src_pan;
      r_d.src_address  = fq_q.src_addr;
      r_d.packet_class = cls;
    end
  end
  assign res_o = r_d;

`include "mac_rx_frame_parse_filter_top_assert.svh"
  `MRFP_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, q_push_i && fv_q && out_stall_i)
  `MRFP_ASSERT_IMPL(a_hold, clk_i, rst_ni, (fv_q && out_stall_i) |=> fv_q)
  `MRFP_ASSERT_IMPL(a_push_valid, clk_i, rst_ni, q_push_i |=> fv_q)

endmodule

@@ sv/mac_rx_frame_parse_filter_top.sv @@
// a frame's result is offered in the cycle after its last byte is accepted
// throughput: one byte per cycle; the last byte stalls only while a result waits
// the single result slot between parser and output sets that figure
// reset clears the frame state and loads default node addresses
module mac_rx_frame_parse_filter_top import mrfp_pkg::*; #(
  parameter int MaxFrameLen = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [2:0]  frame_type_o,
  output logic        ack_request_o,
  output logic        pan_compress_o,
  output logic [7:0]  seq_num_o,
  output logic [1:0]  dst_mode_o,
  output logic [15:0] dst_pan_o,
  output logic [63:0] dst_address_o,
  output logic [1:0]  src_mode_o,
  output logic [15:0] src_pan_o,
  output logic [63:0] src_address_o,
  output logic [1:0]  packet_class_o
);

  logic        omit_q;
  logic [15:0] pan_q, short_q;
  logic [63:0] ext_q;
  logic        push, full;
  frame_t      fr;
  result_t     res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omit_q <= 1'b0; pan_q <= 16'hFFFF; short_q <= 16'hFFFF; ext_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_OMIT:  omit_q  <= cfg_data_i[0];
        REG_PAN:   pan_q   <= cfg_data_i[15:0];
        REG_SHORT: short_q <= cfg_data_i[15:0];
        REG_EXT:   ext_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mrfp_front #(.MaxFrameLen(MaxFrameLen)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .rx_byte_i, .frame_end_i, .in_stall_o,
    .cfg_omit_i(omit_q), .cfg_pan_i(pan_q), .cfg_short_i(short_q), .cfg_ext_i(ext_q),
    .q_push_o(push), .q_data_o(fr), .q_full_i(full)
  );

  mrfp_back u_back (
    .clk_i, .rst_ni, .q_push_i(push), .q_data_i(fr), .q_full_o(full),
    .out_valid_o, .out_stall_i, .res_o(res)
  );

  assign status_o       = res.status;
  assign frame_type_o   = res.frame_type;
  assign ack_request_o  = res.ack_request;
  assign pan_compress_o = res.pan_compress;
  assign seq_num_o      = res.seq_num;
  assign dst_mode_o     = res.dst_mode;
  assign dst_pan_o      = res.dst_pan;
  assign dst_address_o  = res.dst_address;
  assign src_mode_o     = res.src_mode;
  assign src_pan_o      = res.src_pan;
  assign src_address_o  = res.src_address;
  assign packet_class_o = res.packet_class;

endmodule

@@ tb/mac_rx_frame_parse_filter_top_tb.sv @@
module mac_rx_frame_parse_filter_top_tb;
  import mrfp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandBytes = 1000;
  localparam int WatchLimit = 20000;
  localparam int FrameCap = 127;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        frame_end_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [2:0]  frame_type_o;
  logic        ack_request_o;
  logic        pan_compress_o;
  logic [7:0]  seq_num_o;
  logic [1:0]  dst_mode_o;
  logic [15:0] dst_pan_o;
  logic [63:0] dst_address_o;
  logic [1:0]  src_mode_o;
  logic [15:0] src_pan_o;
  logic [63:0] src_address_o;
  logic [1:0]  packet_class_o;

  mac_rx_frame_parse_filter_top dut (.*);

  // node settings as the block should hold them
  logic        nd_omit;
  logic [15:0] nd_pan;
  logic [15:0] nd_short;
  logic [63:0] nd_ext;

  // frame state of the parser model
  logic [15:0] pm_crc;
  int          pm_count;
  int          pm_pos;
  logic [7:0]  pm_hold0, pm_hold1;
  logic [15:0] pm_fc;
  logic [7:0]  pm_seq;
  logic [15:0] pm_dpan, pm_span;
  logic [63:0] pm_daddr, pm_saddr;

  result_t     pending_reports[$];
  int          failures;
  int          quiet_cycles;
  int          sender_pct;
  int          stall_pct;
  logic [7:0]  frame_bytes[$];

  typedef struct {
    int           len;
    logic [191:0] data;
    bit           add_fcs;
    bit           fixed;
    logic [2:0]   status;
  } dir_row_t;
  dir_row_t dir_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] kermit_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
    return r;
  endfunction

  function automatic int field_len(logic [1:0] m);
    return (m == AM_SHORT) ? 2 : 8;
  endfunction

  function automatic int needed_len(logic [15:0] fc);
    int n;
    n = 3;
    if (fc[11:10] != AM_NONE) n += 2 + field_len(fc[11:10]);
    if (fc[15:14] != AM_NONE) n += (fc[6] ? 0 : 2) + field_len(fc[15:14]);
    return n;
  endfunction

  task automatic clear_frame();
    pm_crc = '0; pm_count = 0; pm_pos = 0; pm_hold0 = '0; pm_hold1 = '0;
    pm_fc = '0; pm_seq = '0; pm_dpan = '0; pm_span = '0; pm_daddr = '0; pm_saddr = '0;
  endtask

  task automatic parse_header_byte(logic [7:0] b);
    int n, p, l;
    n = pm_pos;
    p = 3;
    if (pm_pos < 31) pm_pos++;
    if (n == 0) begin
      pm_fc[7:0] = b;
      return;
    end
    if (n == 1) begin
      pm_fc[15:8] = b;
      return;
    end
    if (n == 2) begin
      pm_seq = b;
      return;
    end
    if (pm_fc[11:10] != AM_NONE) begin
      if (n < p + 2) begin
        pm_dpan[8*(n-p) +: 8] = b;
        return;
      end
      p += 2;
      l = field_len(pm_fc[11:10]);
      if (n < p + l) begin
        pm_daddr[8*(n-p) +: 8] = b;
        return;
      end
      p += l;
    end
    if (pm_fc[15:14] != AM_NONE) begin
      if (!pm_fc[6]) begin
        if (n < p + 2) begin
          pm_span[8*(n-p) +: 8] = b;
          return;
        end
        p += 2;
      end
      l = field_len(pm_fc[15:14]);
      if (n < p + l) pm_saddr[8*(n-p) +: 8] = b;
    end
  endtask

  function automatic logic [1:0] address_class();
    logic [1:0] da;
    da = pm_fc[11:10];
    if (da == AM_NONE) return (pm_fc[15:14] != AM_NONE) ? CLS_OTHER : CLS_HOST;
    if (pm_dpan != nd_pan && pm_dpan != 16'hFFFF) return CLS_OTHER;
    if (da == AM_LONG) return (pm_daddr == nd_ext) ? CLS_HOST : CLS_OTHER;
    if (da == AM_SHORT) begin
      if (pm_daddr == {48'd0, nd_short}) return CLS_HOST;
      if (pm_daddr == 64'hFFFF) return CLS_BCAST;
    end
    return CLS_OTHER;
  endfunction

  task automatic receive_byte(logic [7:0] b, logic last, output result_t r);
    logic [7:0] oldest;
    r = '0;
    if (pm_count < FrameCap) begin
      oldest = pm_hold1;
      pm_crc = kermit_step(pm_crc, b);
      pm_hold1 = pm_hold0;
      pm_hold0 = b;
      if (nd_omit) parse_header_byte(b);
      else if (pm_count >= 2) parse_header_byte(oldest);
      pm_count++;
    end
    if (!last) return;
    if (!nd_omit && pm_count < 2) r.status = ST_NO_FCS;
    else if (!nd_omit && pm_crc != 0) r.status = ST_CRC_BAD;
    else if (pm_pos < 3) r.status = ST_TRUNC;
    else if (pm_fc[3]) r.status = ST_SECURED;
    else if (pm_fc[2:0] == FT_ACK && (pm_fc[11:10] != AM_NONE || pm_fc[15:14] != AM_NONE))
      r.status = ST_ACK_ADDR;
    else if (pm_pos < needed_len(pm_fc)) r.status = ST_TRUNC;
    else if (pm_fc[2:0] > 3'd3) r.status = ST_BAD_TYPE;
    else r.status = ST_OK;
    if (r.status == ST_OK || r.status == ST_BAD_TYPE) begin
      r.frame_type = pm_fc[2:0];
      r.ack_request = pm_fc[5];
      r.pan_compress = pm_fc[6];
      r.seq_num = pm_seq;
      r.dst_mode = pm_fc[11:10];
      r.dst_pan = pm_dpan;
      r.dst_address = pm_daddr;
      r.src_mode = pm_fc[15:14];
      r.src_pan = (pm_fc[6] && pm_fc[11:10] != AM_NONE) ? pm_dpan : pm_span;
      r.src_address = pm_saddr;
      r.packet_class = address_class();
    end
    clear_frame();
  endtask

  task automatic send_byte(logic [7:0] b, logic last, bit fixed, logic [2:0] st);
    result_t r;
    while ($urandom_range(99) < sender_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    frame_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    receive_byte(b, last, r);
    if (last) begin
      if (fixed) begin
        r = '0;
        r.status = st;
      end
      pending_reports.push_back(r);
    end
  endtask

  task automatic send_frame(bit fixed, logic [2:0] st);
    for (int i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1, fixed, st);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_OMIT:  nd_omit = v[0];
      REG_PAN:   nd_pan = v[15:0];
      REG_SHORT: nd_short = v[15:0];
      default:   nd_ext = v;
    endcase
  endtask

  task automatic set_node(int round);
    logic [63:0] e;
    e = {$urandom, $urandom};
    if (round == 0) begin
      write_reg(REG_OMIT, 64'd0);
      write_reg(REG_PAN, 64'd0);
      write_reg(REG_SHORT, 64'd0);
      write_reg(REG_EXT, 64'd0);
    end else if (round == 1) begin
      write_reg(REG_OMIT, '1);
      write_reg(REG_PAN, '1);
      write_reg(REG_SHORT, '1);
      write_reg(REG_EXT, '1);
    end else begin
      write_reg(REG_OMIT, {$urandom, 31'($urandom), ($urandom_range(3) == 0)});
      write_reg(REG_PAN, {$urandom, $urandom});
      write_reg(REG_SHORT, {$urandom, $urandom});
      write_reg(REG_EXT, e);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) frame_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic build_frame();
    logic [15:0] fc, c;
    logic [63:0] a;
    int cut, extra;
    frame_bytes.delete();
    fc = 16'($urandom);
    fc[2:0] = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
    fc[3] = ($urandom_range(19) == 0);
    if (fc[2:0] == FT_ACK && $urandom_range(3) != 0) begin
      fc[11:10] = AM_NONE;
      fc[15:14] = AM_NONE;
    end
    push_le(64'(fc), 2);
    push_le(64'($urandom), 1);
    if (fc[11:10] != AM_NONE) begin
      case ($urandom_range(2))
        0: push_le(64'(nd_pan), 2);
        1: push_le(64'hFFFF, 2);
        default: push_le(64'($urandom), 2);
      endcase
      a = {$urandom, $urandom};
      case ($urandom_range(2))
        0: a = (fc[11:10] == AM_SHORT) ? {48'd0, nd_short} : nd_ext;
        1: a = 64'hFFFF;
        default: ;
      endcase
      push_le(a, field_len(fc[11:10]));
    end
    if (fc[15:14] != AM_NONE) begin
      if (!fc[6]) push_le(64'($urandom), 2);
      push_le({$urandom, $urandom}, field_len(fc[15:14]));
    end
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(frame_bytes.size());
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
    extra = ($urandom_range(29) == 0) ? $urandom_range(135, 115) : $urandom_range(8);
    repeat (extra) frame_bytes.push_back(8'($urandom));
    if (!nd_omit) begin
      if ($urandom_range(9) != 0) begin
        c = '0;
        foreach (frame_bytes[i]) c = kermit_step(c, frame_bytes[i]);
        push_le(64'(c), 2);
      end else begin
        push_le(64'($urandom), 2);
      end
    end
    if (frame_bytes.size() == 0) frame_bytes.push_back(8'($urandom));
  endtask

  task automatic add_row(int n, logic [191:0] d, bit fcs, bit fixed, logic [2:0] st);
    dir_row_t row;
    row.len = n; row.data = d; row.add_fcs = fcs; row.fixed = fixed; row.status = st;
    dir_rows.push_back(row);
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s expected %0h got %0h", name, exp_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report with status %0d", status_o);
        failures++;
      end else begin
        e = pending_reports.pop_front();
        check_field("status", 64'(e.status), 64'(status_o));
        check_field("frame_type", 64'(e.frame_type), 64'(frame_type_o));
        check_field("ack_request", 64'(e.ack_request), 64'(ack_request_o));
        check_field("pan_compress", 64'(e.pan_compress), 64'(pan_compress_o));
        check_field("seq_num", 64'(e.seq_num), 64'(seq_num_o));
        check_field("dst_mode", 64'(e.dst_mode), 64'(dst_mode_o));
        check_field("dst_pan", 64'(e.dst_pan), 64'(dst_pan_o));
        check_field("dst_address", e.dst_address, dst_address_o);
        check_field("src_mode", 64'(e.src_mode), 64'(src_mode_o));
        check_field("src_pan", 64'(e.src_pan), 64'(src_pan_o));
        check_field("src_address", e.src_address, src_address_o);
        check_field("packet_class", 64'(e.packet_class), 64'(packet_class_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("mac_rx_frame_parse_filter_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int sent, frames, round;
    logic [15:0] c;
    failures = 0; quiet_cycles = 0; sender_pct = 0; stall_pct = 0;
    rst_ni = 1'b0; in_valid_i = 1'b0; rx_byte_i = '0; frame_end_i = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0; out_stall_i = 1'b0;
    nd_omit = 1'b0; nd_pan = 16'hFFFF; nd_short = 16'hFFFF; nd_ext = '0;
    clear_frame();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(1, 192'hA5, 1'b0, 1'b1, ST_NO_FCS);
    add_row(2, 192'h0000, 1'b0, 1'b1, ST_TRUNC);
    add_row(3, 192'h7F0002, 1'b1, 1'b0, ST_OK);
    add_row(3, 192'h010009, 1'b1, 1'b1, ST_SECURED);
    add_row(3, 192'h010802, 1'b1, 1'b1, ST_ACK_ADDR);
    add_row(3, 192'hFF0007, 1'b1, 1'b0, ST_OK);
    add_row(3, 192'h000801, 1'b1, 1'b1, ST_TRUNC);
    add_row(9, 192'h1234FFFFFFFF558841, 1'b1, 1'b0, ST_OK);
    add_row(23, 192'h1817161514131211ABCD0807060504030201FFFF00CC21, 1'b1, 1'b0, ST_OK);
    add_row(13, 192'h0807060504030201FFFF090401, 1'b1, 1'b0, ST_OK);
    add_row(5, 192'h12340A8041, 1'b1, 1'b0, ST_OK);
    add_row(5, 192'h0000000001, 1'b0, 1'b0, ST_OK);
    add_row(24, '1, 1'b1, 1'b0, ST_OK);
    add_row(24, '0, 1'b1, 1'b0, ST_OK);
    foreach (dir_rows[i]) begin
      frame_bytes.delete();
      c = '0;
      for (int k = 0; k < dir_rows[i].len; k++) begin
        frame_bytes.push_back(dir_rows[i].data[8*k +: 8]);
        c = kermit_step(c, dir_rows[i].data[8*k +: 8]);
      end
      if (dir_rows[i].add_fcs) push_le(64'(c), 2);
      send_frame(dir_rows[i].fixed, dir_rows[i].status);
    end

    sent = 0; frames = 0; round = 0;
    while (sent < RandBytes) begin
      if (frames % 12 == 0) begin
        drain();
        set_node(round);
        round++;
      end
      if (sent < RandBytes / 3) begin
        sender_pct = 8; stall_pct = 68;
      end else if (sent < 2 * RandBytes / 3) begin
        sender_pct = 68; stall_pct = 8;
      end else begin
        sender_pct = 0; stall_pct = 0;
      end
      build_frame();
      sent += frame_bytes.size();
      send_frame(0, ST_OK);
      frames++;
    end
    drain();
    repeat (5) @(posedge clk_i);
    if (failures == 0)
      $display("mac_rx_frame_parse_filter_top_tb OK");
    else
      $display("mac_rx_frame_parse_filter_top_tb NOT OK");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/mrfp_pkg.sv
sv/mrfp_front.sv
sv/mrfp_back.sv
sv/mac_rx_frame_parse_filter_top.sv
tb/mac_rx_frame_parse_filter_top_tb.sv
